>>> sv/ubir_pkg.sv
`default_nettype none

package ubir_pkg;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_TX_DONE = 2'd2,
    OP_RX_CHAR = 2'd3
  } op_e;

  // Selects 6 and 7 are unimplemented and fall to the default arm
  typedef enum logic [2:0] {
    SEL_TBUF = 3'd0,
    SEL_RBUF = 3'd1,
    SEL_TIC  = 3'd2,
    SEL_RIC  = 3'd3,
    SEL_EIC  = 3'd4,
    SEL_TBIC = 3'd5
  } sel_e;

  localparam int unsigned DataW  = 16;
  localparam int unsigned CharW  = 8;
  localparam int unsigned TxW    = 9;
  localparam int unsigned NumIc  = 4;

  localparam int unsigned IrqReqBit = 7;
  localparam int unsigned IrqEnBit  = 6;

  localparam logic [1:0] IC_TX  = 2'd0;
  localparam logic [1:0] IC_RX  = 2'd1;
  localparam logic [1:0] IC_ERR = 2'd2;
  localparam logic [1:0] IC_TBE = 2'd3;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [2:0]       reg_select;
    logic [DataW-1:0] write_data;
    logic [CharW-1:0] rx_char;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             tx_valid;
    logic [CharW-1:0] tx_char;
    logic             rx_accepted;
    logic             tx_overflow;
    logic             irq_request;
  } out_item_t;

endpackage

`default_nettype wire

>>> sv/ubir_if.sv
`default_nettype none

interface ubir_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [2:0]  reg_select;
  logic [15:0] write_data;
  logic [7:0]  rx_char;

  modport source (output valid, output opcode, output reg_select, output write_data,
                  output rx_char, input ready);
  modport sink (input valid, input opcode, input reg_select, input write_data,
                input rx_char, output ready);
endinterface

interface ubir_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        tx_valid;
  logic [7:0]  tx_char;
  logic        rx_accepted;
  logic        tx_overflow;
  logic        irq_request;

  modport source (output valid, output read_data, output tx_valid, output tx_char,
                  output rx_accepted, output tx_overflow, output irq_request,
                  input ready);
  modport sink (input valid, input read_data, input tx_valid, input tx_char,
                input rx_accepted, input tx_overflow, input irq_request,
                output ready);
endinterface

`default_nettype wire

>>> sv/uart_buffer_and_irq_registers.sv
// Channel  Dir  Payload                                              Handshake
// in_i     in   opcode, reg_select, write_data, rx_char              valid/ready
// out_o    out  read_data, tx_valid, tx_char, rx_accepted,           valid/ready
//               tx_overflow, irq_request
//
// One transaction per cycle while out_o.ready stays high; a transaction passes
// the input register, then the register update and result register.
// The register file updates in the same cycle a transaction leaves the input
// register, so back-to-back transactions see each other's effects.
// Reset (rst_ni low, asynchronous) clears all registers and both stage valids.
// A stalled output holds its result and stops the input stage, which then
// holds one transaction and drops in_i.ready.
`default_nettype none

module uart_buffer_and_irq_registers import ubir_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ubir_in_if.sink   in_i,
  ubir_out_if.source out_o
);

  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  out_item_t result;
  logic      out_free;
  logic      exec_fire;
  in_item_t  in_item;

  assign in_item.opcode     = in_i.opcode;
  assign in_item.reg_select = in_i.reg_select;
  assign in_item.write_data = in_i.write_data;
  assign in_item.rx_char    = in_i.rx_char;

  assign out_free  = !out_valid_q || out_o.ready;
  assign exec_fire = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || exec_fire;

  ubir_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .exec_en_i (exec_fire),
    .item_i    (in_q),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q  <= '0;
      out_q <= '0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_q <= in_item;
      end
      if (exec_fire) begin
        out_q <= result;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_data   = out_q.read_data;
  assign out_o.tx_valid    = out_q.tx_valid;
  assign out_o.tx_char     = out_q.tx_char;
  assign out_o.rx_accepted = out_q.rx_accepted;
  assign out_o.tx_overflow = out_q.tx_overflow;
  assign out_o.irq_request = out_q.irq_request;

  a_fire_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> out_valid_q)
    else $error("executed transaction lost before output register");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> (in_valid_q && $stable(in_q)))
    else $error("input stage changed while output stalled");

  a_empty_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_i.ready)
    else $error("input stage empty but not ready");

endmodule

`default_nettype wire

>>> sv/ubir_core.sv
`default_nettype none

module ubir_core import ubir_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      exec_en_i,
  input  wire in_item_t  item_i,
  output      out_item_t result_o
);

  logic [TxW-1:0]         tx_buf_q, tx_buf_d;
  logic [TxW-1:0]         tx_shift_q, tx_shift_d;
  logic                   tx_busy_q, tx_busy_d;
  logic                   tx_full_q, tx_full_d;
  logic [CharW-1:0]       rx_buf_q, rx_buf_d;
  logic                   rx_full_q, rx_full_d;
  logic [NumIc-1:0][DataW-1:0] ic_q, ic_d;

  logic [2:0] ic_off;
  logic [1:0] ic_idx;

  assign ic_off = item_i.reg_select - 3'(SEL_TIC);
  assign ic_idx = ic_off[1:0];

  always_comb begin
    tx_buf_d   = tx_buf_q;
    tx_shift_d = tx_shift_q;
    tx_busy_d  = tx_busy_q;
    tx_full_d  = tx_full_q;
    rx_buf_d   = rx_buf_q;
    rx_full_d  = rx_full_q;
    ic_d       = ic_q;
    result_o   = '0;

    unique case (op_e'(item_i.opcode))
      OP_READ: begin
        unique case (item_i.reg_select)
          SEL_TBUF: result_o.read_data = DataW'(tx_buf_q);
          SEL_RBUF: begin
            result_o.read_data = DataW'(rx_buf_q);
            rx_full_d = 1'b0;
          end
          SEL_TIC, SEL_RIC, SEL_EIC, SEL_TBIC: result_o.read_data = ic_q[ic_idx];
          default: result_o.read_data = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (item_i.reg_select)
          SEL_TBUF: begin
            tx_buf_d = item_i.write_data[TxW-1:0];
            if (!tx_busy_q) begin
              tx_shift_d = item_i.write_data[TxW-1:0];
              tx_busy_d  = 1'b1;
              ic_d[IC_TBE][IrqReqBit] = 1'b1;
            end else if (!tx_full_q) begin
              tx_full_d = 1'b1;
            end else begin
              result_o.tx_overflow = 1'b1;
            end
          end
          SEL_RBUF: rx_buf_d = item_i.write_data[CharW-1:0];
          SEL_TIC, SEL_RIC, SEL_EIC, SEL_TBIC: ic_d[ic_idx] = item_i.write_data;
          default: ;
        endcase
      end
      OP_TX_DONE: begin
        if (tx_busy_q) begin
          result_o.tx_valid = 1'b1;
          result_o.tx_char  = tx_shift_q[CharW-1:0];
          if (tx_full_q) begin
            tx_shift_d = tx_buf_q;
            tx_full_d  = 1'b0;
            ic_d[IC_TBE][IrqReqBit] = 1'b1;
          end else begin
            tx_busy_d = 1'b0;
            ic_d[IC_TX][IrqReqBit] = 1'b1;
          end
        end
      end
      OP_RX_CHAR: begin
        if (!rx_full_q) begin
          rx_buf_d  = item_i.rx_char;
          rx_full_d = 1'b1;
          ic_d[IC_RX][IrqReqBit] = 1'b1;
          result_o.rx_accepted = 1'b1;
        end
      end
    endcase

    // irq level is taken after this transaction's update
    for (int k = 0; k < NumIc; k++) begin
      if (ic_d[k][IrqReqBit] && ic_d[k][IrqEnBit]) begin
        result_o.irq_request = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_buf_q   <= '0;
      tx_shift_q <= '0;
      tx_busy_q  <= 1'b0;
      tx_full_q  <= 1'b0;
      rx_buf_q   <= '0;
      rx_full_q  <= 1'b0;
      ic_q       <= '0;
    end else if (exec_en_i) begin
      tx_buf_q   <= tx_buf_d;
      tx_shift_q <= tx_shift_d;
      tx_busy_q  <= tx_busy_d;
      tx_full_q  <= tx_full_d;
      rx_buf_q   <= rx_buf_d;
      rx_full_q  <= rx_full_d;
      ic_q       <= ic_d;
    end
  end

  // second stage only holds a character while the shifter is busy
  a_full_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_full_q |-> tx_busy_q)
    else $error("tx buffer full while shifter idle");

  a_rx_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_en_i && result_o.rx_accepted) |=> (rx_full_q && ic_q[IC_RX][IrqReqBit]))
    else $error("accepted character not held in rx buffer");

  a_overflow_both_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_en_i && result_o.tx_overflow) |-> (tx_busy_q && tx_full_q))
    else $error("overflow flagged with a free transmit stage");

  a_tx_done_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_en_i && result_o.tx_valid && tx_full_q) |=> (tx_busy_q && !tx_full_q))
    else $error("buffered character not moved into shifter");

endmodule

`default_nettype wire

>>> test/uart_regs_checker.sv
`default_nettype none

// Watches both channels, keeps its own copy of the UART register state and
// compares every result transaction against the predicted one, in order.
module uart_regs_checker import ubir_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ubir_in_if          req_i,
  ubir_out_if         rsp_i,
  output int unsigned err_cnt_o,
  output int unsigned pend_cnt_o
);

  logic [TxW-1:0]   tx_buf;
  logic [TxW-1:0]   tx_shift;
  logic             shift_busy;
  logic             buf_full;
  logic [CharW-1:0] rx_buf;
  logic             rx_full;
  logic [DataW-1:0] ic_regs [NumIc];

  out_item_t   reply_q [$];
  int unsigned mism = 0;

  // Applies one transaction to the register copy, returns the result it causes
  function automatic out_item_t uart_regs_next(in_item_t it);
    out_item_t  r;
    logic [1:0] ic_idx;
    r = '0;
    ic_idx = 2'(it.reg_select - 3'(SEL_TIC));
    case (op_e'(it.opcode))
      OP_READ: begin
        case (sel_e'(it.reg_select))
          SEL_TBUF: r.read_data = DataW'(tx_buf);
          SEL_RBUF: begin
            r.read_data = DataW'(rx_buf);
            rx_full = 1'b0;
          end
          SEL_TIC, SEL_RIC, SEL_EIC, SEL_TBIC:
            r.read_data = ic_regs[ic_idx];
          default: r.read_data = '0;
        endcase
      end
      OP_WRITE: begin
        case (sel_e'(it.reg_select))
          SEL_TBUF: begin
            tx_buf = it.write_data[TxW-1:0];
            if (!shift_busy) begin
              tx_shift   = it.write_data[TxW-1:0];
              shift_busy = 1'b1;
              ic_regs[IC_TBE][IrqReqBit] = 1'b1;
            end else if (!buf_full) begin
              buf_full = 1'b1;
            end else begin
              r.tx_overflow = 1'b1;
            end
          end
          SEL_RBUF: rx_buf = it.write_data[CharW-1:0];
          SEL_TIC, SEL_RIC, SEL_EIC, SEL_TBIC:
            ic_regs[ic_idx] = it.write_data;
          default: ;
        endcase
      end
      OP_TX_DONE: begin
        if (shift_busy) begin
          r.tx_valid = 1'b1;
          r.tx_char  = tx_shift[CharW-1:0];
          if (buf_full) begin
            tx_shift = tx_buf;
            buf_full = 1'b0;
            ic_regs[IC_TBE][IrqReqBit] = 1'b1;
          end else begin
            shift_busy = 1'b0;
            ic_regs[IC_TX][IrqReqBit] = 1'b1;
          end
        end
      end
      default: begin
        if (!rx_full) begin
          rx_buf  = it.rx_char;
          rx_full = 1'b1;
          ic_regs[IC_RX][IrqReqBit] = 1'b1;
          r.rx_accepted = 1'b1;
        end
      end
    endcase
    for (int k = 0; k < NumIc; k++) begin
      if (ic_regs[k][IrqReqBit] && ic_regs[k][IrqEnBit]) r.irq_request = 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (got !== want) begin
      mism++;
      if (mism <= 10)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      tx_buf     = '0;
      tx_shift   = '0;
      shift_busy = 1'b0;
      buf_full   = 1'b0;
      rx_buf     = '0;
      rx_full    = 1'b0;
      for (int k = 0; k < NumIc; k++) ic_regs[k] = '0;
      reply_q.delete();
      err_cnt_o  <= mism;
      pend_cnt_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (reply_q.size() == 0) begin
          mism++;
          if (mism <= 10) $display("%0t: result transaction with nothing expected", $time);
        end else begin
          want = reply_q.pop_front();
          check_field("read_data", want.read_data, rsp_i.read_data);
          check_field("tx_valid", DataW'(want.tx_valid), DataW'(rsp_i.tx_valid));
          check_field("tx_char", DataW'(want.tx_char), DataW'(rsp_i.tx_char));
          check_field("rx_accepted", DataW'(want.rx_accepted), DataW'(rsp_i.rx_accepted));
          check_field("tx_overflow", DataW'(want.tx_overflow), DataW'(rsp_i.tx_overflow));
          check_field("irq_request", DataW'(want.irq_request), DataW'(rsp_i.irq_request));
        end
      end
      if (req_i.valid && req_i.ready)
        reply_q.push_back(uart_regs_next({req_i.opcode, req_i.reg_select,
                                          req_i.write_data, req_i.rx_char}));
      err_cnt_o  <= mism;
      pend_cnt_o <= reply_q.size();
    end
  end

endmodule

`default_nettype wire

>>> test/uart_buffer_and_irq_registers_tb.sv
`default_nettype none

module uart_buffer_and_irq_registers_tb;
  import ubir_pkg::*;

  localparam logic [2:0] SelSpare0  = 3'd6;
  localparam logic [2:0] SelSpare1  = 3'd7;
  localparam int         HoldCycles = 60;
  localparam int         WatchLimit = 2000;
  localparam int         NumRandom  = 1800;

  logic clk_i = 1'b0;
  logic rst_ni;

  ubir_in_if  in_if ();
  ubir_out_if out_if ();

  int unsigned err_cnt;
  int unsigned pend_cnt;
  int unsigned idle_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;

  uart_buffer_and_irq_registers dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  uart_regs_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (in_if),
    .rsp_i      (out_if),
    .err_cnt_o  (err_cnt),
    .pend_cnt_o (pend_cnt)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Called at a rising edge; returns at the edge where the transaction is taken
  task automatic send(logic [1:0] op, logic [2:0] sel, logic [15:0] wd, logic [7:0] rc);
    if (!calm && $urandom_range(99) < 20) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.reg_select <= sel;
    in_if.write_data <= wd;
    in_if.rx_char    <= rc;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Result side; a hold-off request parks ready low long enough to back up the input
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off = 1'b0;
      end
      out_if.ready <= calm || ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [1:0]  op;
    logic [2:0]  sel;
    int unsigned r;
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.opcode     <= OP_READ;
    in_if.reg_select <= SEL_TBUF;
    in_if.write_data <= '0;
    in_if.rx_char    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset values, all-ones/all-zeros data, both transmit stages,
    // overflow, idle line event, refused character, rbuf write, spare selects
    for (int s = 0; s < 8; s++) send(OP_READ, s[2:0], 16'h0000, 8'h00);
    send(OP_WRITE, SEL_TIC, 16'hFFFF, 8'h00);
    send(OP_WRITE, SEL_TIC, 16'h0000, 8'hFF);
    send(OP_WRITE, SEL_TBIC, 16'h0040, 8'h00);
    send(OP_WRITE, SEL_TBUF, 16'hFFFF, 8'h00);
    send(OP_WRITE, SEL_TBUF, 16'h0155, 8'h00);
    send(OP_WRITE, SEL_TBUF, 16'hAAAA, 8'h00);
    send(OP_READ, SEL_TBUF, 16'h0000, 8'h00);
    send(OP_TX_DONE, SEL_TBUF, 16'h0000, 8'h00);
    send(OP_TX_DONE, SEL_TBUF, 16'h0000, 8'h00);
    send(OP_TX_DONE, SEL_TBUF, 16'h0000, 8'h00);
    send(OP_RX_CHAR, SEL_TBUF, 16'h0000, 8'hFF);
    send(OP_RX_CHAR, SEL_TBUF, 16'h0000, 8'h00);
    send(OP_READ, SEL_RBUF, 16'h0000, 8'h00);
    send(OP_WRITE, SEL_RBUF, 16'hABCD, 8'h00);
    send(OP_READ, SEL_RBUF, 16'h0000, 8'h00);
    send(OP_WRITE, SelSpare0, 16'hFFFF, 8'h00);
    send(OP_WRITE, SelSpare1, 16'hFFFF, 8'h00);
    send(OP_WRITE, SEL_EIC, 16'h00C0, 8'h00);
    send(OP_READ, SEL_EIC, 16'h0000, 8'h00);

    for (int n = 0; n < NumRandom; n++) begin
      calm = (n >= 900 && n < 1150);
      if (n == 400 || n == 1500) hold_off = 1'b1;
      r = $urandom_range(99);
      if (r < 25)      op = OP_READ;
      else if (r < 60) op = OP_WRITE;
      else if (r < 80) op = OP_TX_DONE;
      else             op = OP_RX_CHAR;
      // tbuf writes are favored so the overflow path is hit often
      if (op == OP_WRITE && $urandom_range(1)) sel = SEL_TBUF;
      else sel = 3'($urandom_range(7));
      send(op, sel, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)));
    end
    calm = 1'b0;
    in_if.valid <= 1'b0;

    do @(posedge clk_i); while (pend_cnt != 0);
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
sv/ubir_pkg.sv
sv/ubir_if.sv
sv/ubir_core.sv
sv/uart_buffer_and_irq_registers.sv
test/uart_regs_checker.sv
test/uart_buffer_and_irq_registers_tb.sv
